// ===== rtl/bdpc_pkg.sv =====
// ============================================================================
// bdpc_pkg - shared types and constants for the button press classifier
// Event and gesture codes, register indexes, reset values, config bundle.
// ============================================================================
package bdpc_pkg;

    localparam int CFG_W              = 16;
    localparam int CFG_ADDR_W         = 2;
    localparam int TIME_WIDTH_DEFAULT = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_TICKS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] DOUBLE_GAP_TICKS_RST = 16'd500;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DEBOUNCE_TICKS   = 2'd0,
        REG_LONG_PRESS_TICKS = 2'd1,
        REG_DOUBLE_GAP_TICKS = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        G_NONE   = 2'd0,
        G_SHORT  = 2'd1,
        G_LONG   = 2'd2,
        G_DOUBLE = 2'd3
    } gesture_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] long_press_ticks;
        logic [CFG_W-1:0] double_gap_ticks;
    } cfg_t;

endpackage

// ===== rtl/bdpc_debounce.sv =====
// ============================================================================
// bdpc_debounce - one-shot debounce counter
// A falling raw edge reloads the count; expiry samples the raw level.
// ============================================================================
module bdpc_debounce (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,       // one tick processed
    input  logic                      level,      // raw level of that tick
    input  logic [bdpc_pkg::CFG_W-1:0] debounce_ticks,
    output bdpc_pkg::event_t          event_code  // valid with step
);
    import bdpc_pkg::*;

    logic             prev_level_reg, prev_level_next;
    logic             running_reg,    running_next;
    logic [CFG_W-1:0] remaining_reg,  remaining_next;

    always_comb
    begin
        prev_level_next = level;
        running_next    = running_reg;
        remaining_next  = remaining_reg;
        event_code      = EV_NONE;
        if (prev_level_reg && !level)
        begin
            running_next   = 1'b1;
            remaining_next = debounce_ticks;
        end
        else if (running_reg)
        begin
            // zero and one both expire on the next tick
            if (remaining_reg <= CFG_W'(1))
            begin
                running_next   = 1'b0;
                remaining_next = '0;
                event_code     = level ? EV_RELEASE : EV_PRESS;
            end
            else
            begin
                remaining_next = remaining_reg - CFG_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b1;
            running_reg    <= 1'b0;
            remaining_reg  <= '0;
        end
        else if (step)
        begin
            prev_level_reg <= prev_level_next;
            running_reg    <= running_next;
            remaining_reg  <= remaining_next;
        end
    end

    // idle counter always sits at zero
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> remaining_reg == '0)
        else $error("debounce count nonzero while idle");

    // an event only comes from a running count
    a_event_running: assert property (@(posedge clk) disable iff (!rst_n)
        (step && event_code != EV_NONE) |-> running_reg)
        else $error("debounce event without running count");

    // expiry stops the count
    a_expiry_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (step && event_code != EV_NONE) |=> !running_reg)
        else $error("count still running after expiry");

endmodule

// ===== rtl/bdpc_classifier.sv =====
// ============================================================================
// bdpc_classifier - short / long / double press classifier
// Pending flag plus saturating tick count since the last debounced press.
// ============================================================================
module bdpc_classifier #(
    parameter int TIME_WIDTH = bdpc_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  bdpc_pkg::event_t     event_code,
    input  bdpc_pkg::cfg_t       cfg,
    output bdpc_pkg::gesture_t   gesture
);
    import bdpc_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

    logic [TIME_WIDTH-1:0] ticks_reg, ticks_next, ticks_inc;
    logic                  pending_reg, pending_next;
    logic [CMP_W-1:0]      ticks_cmp;

    always_comb
    begin
        ticks_inc    = (ticks_reg == '1) ? ticks_reg : ticks_reg + TIME_WIDTH'(1);
        ticks_cmp    = CMP_W'(ticks_inc);
        ticks_next   = ticks_inc;
        pending_next = pending_reg;
        gesture      = G_NONE;
        case (event_code)
            EV_PRESS:
            begin
                if (pending_reg && ticks_cmp <= CMP_W'(cfg.double_gap_ticks))
                begin
                    gesture      = G_DOUBLE;
                    pending_next = 1'b0;
                end
                else
                begin
                    pending_next = 1'b1;
                end
                ticks_next = '0;
            end
            EV_RELEASE:
            begin
                if (pending_reg)
                begin
                    gesture = (ticks_cmp >= CMP_W'(cfg.long_press_ticks)) ? G_LONG
                                                                          : G_SHORT;
                    pending_next = 1'b0;
                end
            end
            default:
            begin
                gesture = G_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else if (step)
        begin
            ticks_reg   <= ticks_next;
            pending_reg <= pending_next;
        end
    end

    // a gesture closes the pending press
    a_gesture_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && gesture != G_NONE) |=> !pending_reg)
        else $error("pending flag survived a gesture");

    // a press restarts the gap count
    a_press_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        (step && event_code == EV_PRESS) |=> ticks_reg == '0)
        else $error("tick count not cleared on press");

    // any gesture needs a pending press
    a_gesture_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (step && gesture != G_NONE) |-> pending_reg)
        else $error("gesture without pending press");

endmodule

// ===== rtl/button_debounce_press_classifier.sv =====
// ============================================================================
// button_debounce_press_classifier - debounced button with gesture output
// Pipeline: a tick passes the input reg, then the result reg.
// Throughput: one tick word per cycle while the output is not stalled; a result
//   waits in its output register while the next tick is taken into the input register.
// Reset (rst_n low, async): both stages empty, level released, debounce idle,
//   no pending press, tick count zero, registers at 50 / 1000 / 500.
// ============================================================================
module button_debounce_press_classifier #(
    parameter int TIME_WIDTH = bdpc_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // tick input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [0] button_level, [7:1] zero
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [1:0] debounced_event,
                                                       // [3:2] gesture, [7:4] zero
    // configuration writes
    input  logic                            cfg_we,
    input  logic [bdpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bdpc_pkg::CFG_W-1:0]      cfg_wdata
);
    import bdpc_pkg::*;

    // ---------------- configuration registers ----------------
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_TICKS_RST;
            cfg_reg.long_press_ticks <= LONG_PRESS_TICKS_RST;
            cfg_reg.double_gap_ticks <= DOUBLE_GAP_TICKS_RST;
        end
        else if (cfg_we)
        begin
            // unknown index is dropped
            case (cfg_addr)
                REG_DEBOUNCE_TICKS:   cfg_reg.debounce_ticks   <= cfg_wdata;
                REG_LONG_PRESS_TICKS: cfg_reg.long_press_ticks <= cfg_wdata;
                REG_DOUBLE_GAP_TICKS: cfg_reg.double_gap_ticks <= cfg_wdata;
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic     in_valid_reg;
    logic     level_reg;
    logic     step;         // tick moves from input reg into result reg
    logic     out_valid_reg;
    event_t   event_reg;
    gesture_t gesture_reg;
    event_t   event_code;
    gesture_t gesture;

    // result slot free or draining this cycle
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            level_reg <= s_tdata[0];
        end
    end

    // ---------------- single-pass update ----------------
    bdpc_debounce u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .level          (level_reg),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .event_code     (event_code)
    );

    bdpc_classifier #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_classifier (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .event_code (event_code),
        .cfg        (cfg_reg),
        .gesture    (gesture)
    );

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            event_reg   <= event_code;
            gesture_reg <= gesture;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, gesture_reg, event_reg};

    // ---------------- checks ----------------
    // double press only ever rides on a press event
    a_double_on_press: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && gesture_reg == G_DOUBLE) |-> event_reg == EV_PRESS)
        else $error("double press without press event");

    // short / long only on a release
    a_len_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (gesture_reg == G_SHORT || gesture_reg == G_LONG))
            |-> event_reg == EV_RELEASE)
        else $error("short/long gesture without release event");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !step)
        else $error("result register overwritten while stalled");

    // an input stall means a tick is already held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with empty stage");

endmodule
